// ===== hw/rtl/vsth_pkg.sv =====
// Shared constants, types and codes for the top-down heightmap decoder.
package vsth_pkg;

    // Map geometry and depth range.
    localparam int MAP_SIDE    = 512;
    localparam int LEVELS      = 64;
    localparam int PREVIEW_DIV = 6;

    // Derived widths.
    localparam int COORD_W = (MAP_SIDE > 2) ? $clog2(MAP_SIDE) : 1;
    localparam int LVL_W   = $clog2(LEVELS + 1);
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int RUN_W   = BYTE_W + 1;
    localparam int RGB_W   = 24;
    localparam int PIX_W   = 9;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COLORS
    } t_phase;

    // One pixel write leaving the parser, before preview scaling.
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RGB_W-1:0]   color;
        logic               last;
    } t_result;

endpackage

// ===== hw/rtl/vsth_scale.sv =====
// Preview coordinate scaler: optional divide by the preview factor.
module vsth_scale
    import vsth_pkg::*;
(
    input  logic [COORD_W-1:0] i_coord,
    input  logic               i_enable,
    output logic [PIX_W-1:0]   o_pixel
);

    // Reciprocal with enough fraction bits that the rounded-up value is exact
    // for every coordinate (quotient error stays below one divisor step).
    localparam int DIV_SHIFT = COORD_W + 4;
    localparam int RCP       = (2 ** DIV_SHIFT + PREVIEW_DIV - 1) / PREVIEW_DIV;
    localparam int RCP_W     = DIV_SHIFT + 1;
    localparam int PROD_W    = COORD_W + RCP_W;

    logic [PROD_W-1:0]  prod;
    logic [COORD_W-1:0] quot;

    // Multiply by the reciprocal and keep the integer part.
    assign prod = PROD_W'(i_coord) * PROD_W'(RCP);
    assign quot = prod[DIV_SHIFT +: COORD_W];

    // Select the scaled or plain coordinate.
    assign o_pixel = i_enable ? PIX_W'(quot) : PIX_W'(i_coord);

endmodule

// ===== hw/rtl/vsth_parser.sv =====
// Span parser: column tracking, topmost voxel search and pixel write generation.
module vsth_parser
    import vsth_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [WORD_W-1:0] i_word,
    output t_result           o_result
);

    // State registers.
    t_phase             r_phase, n_phase;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    logic [LVL_W-1:0]   r_hl, n_hl;
    logic [RGB_W-1:0]   r_hc, n_hc;
    logic [RUN_W-1:0]   r_run, n_run;
    logic [RUN_W-1:0]   r_top, n_top;
    logic [BYTE_W-1:0]  r_bot, n_bot;
    logic [BYTE_W-1:0]  r_pend, n_pend;
    logic [RGB_W-1:0]   r_fbc, n_fbc;
    logic               r_final, n_final;

    // Header fields and derived values.
    logic [BYTE_W-1:0] count, ts, te, air;
    logic [RUN_W-1:0]  hdr_tlen, hdr_top;
    logic [BYTE_W-1:0] hdr_n, hdr_bot, pend_z;
    logic              pend_take;
    // Color word values.
    logic              col_top_act, col_bot_act, col_take, col_done;
    logic [RUN_W-1:0]  col_top_nx;
    logic [BYTE_W-1:0] col_bot_nx;
    logic              is_header, hdr_fin, finish;
    logic [LVL_W-1:0]  hl_tk;
    logic [RGB_W-1:0]  hc_tk;
    logic              x_last, y_last;

    // Decode the word in both interpretations.
    always_comb begin
        count     = i_word[0*BYTE_W +: BYTE_W];
        ts        = i_word[1*BYTE_W +: BYTE_W];
        te        = i_word[2*BYTE_W +: BYTE_W];
        air       = i_word[3*BYTE_W +: BYTE_W];
        hdr_tlen  = (te >= ts) ? (RUN_W'(te) - RUN_W'(ts) + RUN_W'(1)) : '0;
        hdr_n     = count - BYTE_W'(1);
        hdr_top   = (hdr_tlen < RUN_W'(hdr_n)) ? hdr_tlen : RUN_W'(hdr_n);
        hdr_bot   = hdr_n - hdr_top[BYTE_W-1:0];
        // Buried bottom colors sit just below the air start; clamp at zero.
        pend_z    = (air >= r_pend) ? (air - r_pend) : '0;
        pend_take = (r_pend != '0) && (RUN_W'(pend_z) < RUN_W'(r_hl));

        col_top_act = (r_top != '0);
        col_bot_act = !col_top_act && (r_bot != '0);
        col_take    = col_top_act && (r_run < RUN_W'(r_hl));
        col_top_nx  = col_top_act ? (r_top - RUN_W'(1)) : r_top;
        col_bot_nx  = col_bot_act ? (r_bot - BYTE_W'(1)) : r_bot;
        col_done    = (col_top_nx == '0) && (col_bot_nx == '0);

        is_header = (r_phase != PH_COLORS);
        hdr_fin   = (count == '0) && (hdr_tlen == '0);
        finish    = i_step && (is_header ? hdr_fin : (col_done && r_final));

        // Running minimum after this word's contribution.
        hl_tk = r_hl;
        hc_tk = r_hc;
        if (is_header && pend_take) begin
            hl_tk = pend_z[LVL_W-1:0];
            hc_tk = r_fbc;
        end else if (!is_header && col_take) begin
            hl_tk = r_run[LVL_W-1:0];
            hc_tk = i_word[RGB_W-1:0];
        end

        x_last = (r_x == COORD_W'(MAP_SIDE - 1));
        y_last = (r_y == COORD_W'(MAP_SIDE - 1));
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (count == '0) begin
                        n_phase = hdr_fin ? PH_HEADER : PH_COLORS;
                    end else begin
                        n_phase = (hdr_n != '0) ? PH_COLORS : PH_HEADER;
                    end
                end
                PH_COLORS: begin
                    n_phase = col_done ? PH_HEADER : PH_COLORS;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    // Datapath updates and pixel write.
    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_hl    = r_hl;
        n_hc    = r_hc;
        n_run   = r_run;
        n_top   = r_top;
        n_bot   = r_bot;
        n_pend  = r_pend;
        n_fbc   = r_fbc;
        n_final = r_final;

        o_result.valid = finish;
        o_result.x     = r_x;
        o_result.y     = r_y;
        o_result.color = hc_tk;
        o_result.last  = x_last && y_last;

        if (i_step) begin
            n_hl = hl_tk;
            n_hc = hc_tk;
            if (is_header) begin
                n_run = RUN_W'(ts);
                if (count == '0) begin
                    n_final = 1'b1;
                    n_top   = hdr_tlen;
                    n_bot   = '0;
                    n_pend  = '0;
                end else begin
                    n_final = 1'b0;
                    n_top   = hdr_top;
                    n_bot   = hdr_bot;
                    n_pend  = hdr_bot;
                end
            end else begin
                n_top = col_top_nx;
                n_bot = col_bot_nx;
                if (col_take) begin
                    n_run = r_run + RUN_W'(1);
                end else if (col_top_act) begin
                    n_run = r_run + RUN_W'(1);
                end
                // The first bottom color is the one whose z the next header settles.
                if (col_bot_act && (r_bot == r_pend)) begin
                    n_fbc = i_word[RGB_W-1:0];
                end
            end

            // Column end: clear the search and move to the next column.
            if (finish) begin
                n_hl    = LVL_W'(LEVELS);
                n_hc    = '0;
                n_final = 1'b0;
                n_pend  = '0;
                n_top   = '0;
                n_bot   = '0;
                if (x_last) begin
                    n_x = '0;
                    n_y = y_last ? '0 : (r_y + COORD_W'(1));
                end else begin
                    n_x = r_x + COORD_W'(1);
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_x     <= '0;
            r_y     <= '0;
            r_hl    <= LVL_W'(LEVELS);
            r_hc    <= '0;
            r_run   <= '0;
            r_top   <= '0;
            r_bot   <= '0;
            r_pend  <= '0;
            r_fbc   <= '0;
            r_final <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_x     <= n_x;
            r_y     <= n_y;
            r_hl    <= n_hl;
            r_hc    <= n_hc;
            r_run   <= n_run;
            r_top   <= n_top;
            r_bot   <= n_bot;
            r_pend  <= n_pend;
            r_fbc   <= n_fbc;
            r_final <= n_final;
        end
    end

    // The best level never rises above the empty-column value.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hl <= LVL_W'(LEVELS))
        else $error("highest level above reset value");

    // While expecting a header no color words are outstanding.
    a_header_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> ((r_top == '0) && (r_bot == '0)))
        else $error("header phase with color words outstanding");

    // The color phase always has at least one color word left.
    a_colors_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COLORS) |-> ((r_top != '0) || (r_bot != '0)))
        else $error("color phase with nothing left");

    // A pixel write leaves the search cleared for the next column.
    a_column_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.valid) |=>
            ((r_phase == PH_HEADER) && (r_hl == LVL_W'(LEVELS)) && (r_hc == '0)))
        else $error("column state not cleared after pixel write");

endmodule

// ===== hw/rtl/voxel_span_topdown_heightmap.sv =====
// A word waits in an input register, its pixel write in a result register.
// Throughput: one stream word per cycle unless the pixel output stalls; the parser
// state update is the loop that sets it.
// Reset (synchronous, active low) clears the parser to expect a header at
// column (0,0), empties both registers and clears preview mode.
// Top level of the top-down heightmap decoder.
module voxel_span_topdown_heightmap
    import vsth_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_word_valid,
    output logic              o_word_stall,
    input  logic [WORD_W-1:0] i_stream_word,
    output logic              o_pix_valid,
    input  logic              i_pix_stall,
    output logic [PIX_W-1:0]  o_pixel_x,
    output logic [PIX_W-1:0]  o_pixel_y,
    output logic [RGB_W-1:0]  o_color_rgb,
    output logic              o_frame_last
);

    logic              r_preview;
    logic              r_in_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_px, r_py;
    logic [RGB_W-1:0]  r_color;
    logic              r_last;
    logic              advance, step;
    t_result           result;
    logic [PIX_W-1:0]  scaled_x, scaled_y;

    // Pipeline moves when the result register is empty or being taken.
    assign advance      = !r_out_valid || !i_pix_stall;
    assign step         = r_in_valid && advance;
    assign o_word_stall = r_in_valid && !advance;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preview <= 1'b0;
        end else if (i_cfg_we) begin
            r_preview <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_word_valid && !o_word_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word_valid && !o_word_stall) begin
            r_word <= i_stream_word;
        end
    end

    vsth_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_word),
        .o_result (result)
    );

    vsth_scale u_scale_x (
        .i_coord  (result.x),
        .i_enable (r_preview),
        .o_pixel  (scaled_x)
    );

    vsth_scale u_scale_y (
        .i_coord  (result.y),
        .i_enable (r_preview),
        .o_pixel  (scaled_y)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.valid) begin
            r_px    <= scaled_x;
            r_py    <= scaled_y;
            r_color <= result.color;
            r_last  <= result.last;
        end
    end

    assign o_pix_valid  = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_color_rgb  = r_color;
    assign o_frame_last = r_last;

endmodule
